// File: hw/rtl/vertex_weld_hash_table_macros.svh
// ----------------------------------------------------------------------------
// Vertex weld hash table assertion macros
// Concurrent assertion helpers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef VERTEX_WELD_HASH_TABLE_MACROS_SVH
`define VERTEX_WELD_HASH_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside reset
`define VWH_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vwh assertion failed");
// Condition must never be true outside reset
`define VWH_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("vwh forbidden condition");
`else
`define VWH_ASSERT(lbl, clk, rst_n, prop)
`define VWH_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: hw/rtl/vwh_pkg.sv
// ----------------------------------------------------------------------------
// Vertex weld hash table package
// Sizes, codes and sequencer states shared by the welding block.
// ----------------------------------------------------------------------------
package vwh_pkg;

  localparam int unsigned Buckets   = 128;
  localparam int unsigned VertexCap = 4096;

  localparam int unsigned CoordW = 32;
  localparam int unsigned TolW   = 31;
  localparam int unsigned IdW    = 12;
  // bucket index / quotient bits
  localparam int unsigned BktW   = $clog2(Buckets);
  // entry address bits
  localparam int unsigned AddrW  = $clog2(VertexCap);
  // head/link code: 0 empty, n+1 entry n; also the fill count
  localparam int unsigned LinkW  = $clog2(VertexCap + 1);
  // positive range and offset, below 2^33
  localparam int unsigned SpanW  = CoordW + 1;
  localparam int unsigned NumW   = SpanW + BktW;
  localparam int unsigned DivCntW = $clog2(BktW + 1);
  // stored entry: link, z, y, x from the top bits down
  localparam int unsigned EntW   = 3 * CoordW + LinkW;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MERGE_TOL = 2'd0,
    CFG_Z_MIN     = 2'd1,
    CFG_Z_MAX     = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    REQ_FIND  = 1'b0,
    REQ_CLEAR = 1'b1
  } req_type_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_DIV,
    S_HEAD,
    S_HEAD_USE,
    S_WALK,
    S_CMP,
    S_INSERT,
    S_RESULT
  } state_e;

endpackage

// File: hw/rtl/vertex_weld_hash_table.sv
// ----------------------------------------------------------------------------
// Vertex weld hash table
// Finds a vertex within tolerance of the request or inserts it; clear empties all.
// ----------------------------------------------------------------------------
// channel | dir | handshake              | payload
// s_axis  | in  | s_axis_tvalid/tready   | tdata x,y,z; tuser req_type
// m_axis  | out | m_axis_tvalid/tready   | tdata vertex_id; tuser is_new,full
// cfg     | in  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// A find steps through PREP, HEAD and HEAD_USE, then WALK and CMP for each chain
// entry compared, and on a miss INSERT, before RESULT; the entry RAM's registered
// read is why each entry needs both WALK and CMP. A z strictly inside the range
// first runs MUL and the bucket divider (one quotient bit per cycle). A clear goes
// from accept straight to RESULT. A new request is accepted only in IDLE.
// Reset empties all buckets through per-bucket valid bits, no sweep.
// The result waits in an output register; a stalled output holds the
// sequencer in its result state until the register is free.
// ----------------------------------------------------------------------------
`include "vertex_weld_hash_table_macros.svh"

module vertex_weld_hash_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // coord_x[31:0], coord_y[63:32], coord_z[95:64]
  input  logic [0:0]  s_axis_tuser,  // req_type[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // vertex_id[11:0], zero[15:12]
  output logic [1:0]  m_axis_tuser,  // is_new[0], table_full[1]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [vwh_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  vwh_pkg::state_e state_q, state_d;

  logic [vwh_pkg::TolW-1:0]   tol_q;
  logic signed [vwh_pkg::CoordW-1:0] zmin_q, zmax_q;

  logic signed [vwh_pkg::CoordW-1:0] x_q, y_q, z_q;
  logic [vwh_pkg::SpanW-1:0]  d_q, range_q;
  logic [vwh_pkg::NumW-1:0]   rem_q, den_q;
  logic [vwh_pkg::BktW-1:0]   bkt_q;
  logic [vwh_pkg::DivCntW-1:0] div_cnt_q;
  logic [vwh_pkg::LinkW-1:0]  link_q, head_q, cnt_q;
  logic [vwh_pkg::Buckets-1:0] head_vld_q;

  logic [vwh_pkg::IdW-1:0]    res_id_q;
  logic                       res_new_q, res_full_q;
  logic                       m_valid_q;
  logic [vwh_pkg::IdW-1:0]    m_id_q;
  logic                       m_new_q, m_full_q;

  logic [vwh_pkg::LinkW-1:0]  head_rdata;
  logic [vwh_pkg::EntW-1:0]   ent_rdata, ent_wdata;
  logic                       head_we, ent_we;
  logic [vwh_pkg::AddrW-1:0]  ent_raddr, ent_waddr;

  logic                       in_acc;
  logic signed [vwh_pkg::SpanW:0] range_s, d_s;
  logic [vwh_pkg::NumW-1:0]   rem_sub;
  logic                       rem_ge;
  logic signed [vwh_pkg::CoordW:0] dx, dy, dz;
  logic [vwh_pkg::CoordW:0]   ax, ay, az;
  logic                       close;
  logic                       out_free;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == vwh_pkg::S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !m_valid_q || m_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= vwh_pkg::TolW'(128);
      zmin_q <= '0;
      zmax_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vwh_pkg::CFG_MERGE_TOL: tol_q  <= cfg_data_i[vwh_pkg::TolW-1:0];
        vwh_pkg::CFG_Z_MIN:     zmin_q <= cfg_data_i;
        vwh_pkg::CFG_Z_MAX:     zmax_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // bucket span, exact in 34 bits
  assign range_s = (vwh_pkg::SpanW+1)'(zmax_q) - (vwh_pkg::SpanW+1)'(zmin_q);
  assign d_s     = (vwh_pkg::SpanW+1)'(z_q)    - (vwh_pkg::SpanW+1)'(zmin_q);

  // divider step: one quotient bit per cycle
  assign rem_ge  = (rem_q >= den_q);
  assign rem_sub = rem_q - den_q;

  // per-axis distance check against the stored entry
  assign dx = (vwh_pkg::CoordW+1)'($signed(ent_rdata[vwh_pkg::CoordW-1:0]))
            - (vwh_pkg::CoordW+1)'(x_q);
  assign dy = (vwh_pkg::CoordW+1)'($signed(ent_rdata[2*vwh_pkg::CoordW-1:vwh_pkg::CoordW]))
            - (vwh_pkg::CoordW+1)'(y_q);
  assign dz = (vwh_pkg::CoordW+1)'($signed(ent_rdata[3*vwh_pkg::CoordW-1:2*vwh_pkg::CoordW]))
            - (vwh_pkg::CoordW+1)'(z_q);
  assign ax = dx[vwh_pkg::CoordW] ? -dx : dx;
  assign ay = dy[vwh_pkg::CoordW] ? -dy : dy;
  assign az = dz[vwh_pkg::CoordW] ? -dz : dz;
  assign close = (ax <= (vwh_pkg::CoordW+1)'(tol_q)) && (ay <= (vwh_pkg::CoordW+1)'(tol_q))
              && (az <= (vwh_pkg::CoordW+1)'(tol_q));

  // RAM addressing
  assign ent_raddr = vwh_pkg::AddrW'(link_q - vwh_pkg::LinkW'(1));
  assign ent_waddr = vwh_pkg::AddrW'(cnt_q);
  assign ent_wdata = {head_q, z_q, y_q, x_q};
  assign ent_we    = (state_q == vwh_pkg::S_INSERT) && (cnt_q != vwh_pkg::LinkW'(vwh_pkg::VertexCap));
  assign head_we   = ent_we;

  vwh_ram #(
    .Width (vwh_pkg::LinkW),
    .Depth (vwh_pkg::Buckets)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (bkt_q),
    .wdata_i (cnt_q + vwh_pkg::LinkW'(1)),
    .raddr_i (bkt_q),
    .rdata_o (head_rdata)
  );

  vwh_ram #(
    .Width (vwh_pkg::EntW),
    .Depth (vwh_pkg::VertexCap)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vwh_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vwh_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (s_axis_tuser[0] == vwh_pkg::REQ_CLEAR) ? vwh_pkg::S_RESULT
                                                             : vwh_pkg::S_PREP;
        end
      end
      vwh_pkg::S_PREP: begin
        if (range_s <= 0 || d_s <= 0 || d_s >= range_s) begin
          state_d = vwh_pkg::S_HEAD;
        end else begin
          state_d = vwh_pkg::S_MUL;
        end
      end
      vwh_pkg::S_MUL:  state_d = vwh_pkg::S_DIV;
      vwh_pkg::S_DIV: begin
        if (div_cnt_q == vwh_pkg::DivCntW'(1)) begin
          state_d = vwh_pkg::S_HEAD;
        end
      end
      vwh_pkg::S_HEAD:     state_d = vwh_pkg::S_HEAD_USE;
      vwh_pkg::S_HEAD_USE: state_d = vwh_pkg::S_WALK;
      vwh_pkg::S_WALK: begin
        state_d = (link_q == '0 || link_q > cnt_q) ? vwh_pkg::S_INSERT : vwh_pkg::S_CMP;
      end
      vwh_pkg::S_CMP:    state_d = close ? vwh_pkg::S_RESULT : vwh_pkg::S_WALK;
      vwh_pkg::S_INSERT: state_d = vwh_pkg::S_RESULT;
      vwh_pkg::S_RESULT: begin
        if (out_free) begin
          state_d = vwh_pkg::S_IDLE;
        end
      end
      default: state_d = vwh_pkg::S_IDLE;
    endcase
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      vwh_pkg::S_IDLE: begin
        x_q        <= s_axis_tdata[31:0];
        y_q        <= s_axis_tdata[63:32];
        z_q        <= s_axis_tdata[95:64];
        res_id_q   <= '0;
        res_new_q  <= 1'b0;
        res_full_q <= 1'b0;
      end
      vwh_pkg::S_PREP: begin
        d_q     <= d_s[vwh_pkg::SpanW-1:0];
        range_q <= range_s[vwh_pkg::SpanW-1:0];
        if (range_s <= 0 || d_s <= 0) begin
          bkt_q <= '0;
        end else begin
          bkt_q <= vwh_pkg::BktW'(vwh_pkg::Buckets - 1);
        end
      end
      vwh_pkg::S_MUL: begin
        // scale by Buckets-1 as a shift and a subtract
        rem_q     <= (vwh_pkg::NumW'(d_q) << vwh_pkg::BktW) - vwh_pkg::NumW'(d_q);
        den_q     <= vwh_pkg::NumW'(range_q) << (vwh_pkg::BktW - 1);
        div_cnt_q <= vwh_pkg::DivCntW'(vwh_pkg::BktW);
        bkt_q     <= '0;
      end
      vwh_pkg::S_DIV: begin
        if (rem_ge) begin
          rem_q <= rem_sub;
        end
        den_q     <= den_q >> 1;
        bkt_q     <= {bkt_q[vwh_pkg::BktW-2:0], rem_ge};
        div_cnt_q <= div_cnt_q - vwh_pkg::DivCntW'(1);
      end
      vwh_pkg::S_HEAD_USE: begin
        link_q <= head_vld_q[bkt_q] ? head_rdata : '0;
        head_q <= head_vld_q[bkt_q] ? head_rdata : '0;
      end
      vwh_pkg::S_CMP: begin
        if (close) begin
          res_id_q <= vwh_pkg::IdW'(ent_raddr);
        end else begin
          link_q <= ent_rdata[vwh_pkg::EntW-1:3*vwh_pkg::CoordW];
        end
      end
      vwh_pkg::S_INSERT: begin
        if (cnt_q == vwh_pkg::LinkW'(vwh_pkg::VertexCap)) begin
          res_full_q <= 1'b1;
        end else begin
          res_id_q  <= vwh_pkg::IdW'(cnt_q);
          res_new_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // fill count and bucket valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      head_vld_q <= '0;
    end else if (in_acc && s_axis_tuser[0] == vwh_pkg::REQ_CLEAR) begin
      cnt_q      <= '0;
      head_vld_q <= '0;
    end else if (ent_we) begin
      cnt_q             <= cnt_q + vwh_pkg::LinkW'(1);
      head_vld_q[bkt_q] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == vwh_pkg::S_RESULT && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // hold payload until a new result lands
  always_ff @(posedge clk_i) begin
    if (state_q == vwh_pkg::S_RESULT && out_free) begin
      m_id_q   <= res_id_q;
      m_new_q  <= res_new_q;
      m_full_q <= res_full_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0, m_id_q};
  assign m_axis_tuser  = {m_full_q, m_new_q};

  `VWH_ASSERT_NEVER(a_cnt_cap, clk_i, rst_ni, cnt_q > vwh_pkg::LinkW'(vwh_pkg::VertexCap))
  `VWH_ASSERT_NEVER(a_new_full, clk_i, rst_ni, m_valid_q && m_new_q && m_full_q)
  `VWH_ASSERT(a_walk_in_range, clk_i, rst_ni, state_q == vwh_pkg::S_CMP |-> link_q <= cnt_q)
  `VWH_ASSERT(a_ins_grows, clk_i, rst_ni, ent_we |=> cnt_q == $past(cnt_q) + vwh_pkg::LinkW'(1))

endmodule

// File: hw/rtl/vwh_ram.sv
// ----------------------------------------------------------------------------
// Vertex weld hash table RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module vwh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
